// ===== rtl/midi_note_envelope_controller_top_defines.svh =====
// Assertion macros for the MIDI note envelope controller.
// Included by the top level; it needs clk and arst_n in the scope of each use.
`ifndef MIDI_NOTE_ENVELOPE_CONTROLLER_TOP_DEFINES_SVH
`define MIDI_NOTE_ENVELOPE_CONTROLLER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define MNEC_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("mnec: assertion failed");

// A condition that must be followed by another in the next cycle.
`define MNEC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mnec: assertion failed");

`else

`define MNEC_ASSERT(lbl, expr)
`define MNEC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/mnec_pkg.sv =====
// Shared types and constants of the MIDI note envelope controller.
// No dependencies; used by every module of the block.
package mnec_pkg;

	// Widths that follow from the fixed word fields.
	localparam int VAL_W  = 16;
	localparam int CODE_W = 12;
	localparam int NOTE_W = 7;
	localparam int SEL_W  = 4;
	localparam int STEP_W = 8;

	// Operation codes of an input word.
	typedef enum logic [2:0] {
		OP_MIDI       = 3'd0,
		OP_TICK       = 3'd1,
		OP_LOAD_PITCH = 3'd2,
		OP_LOAD_LEVEL = 3'd3,
		OP_LOAD_ENV   = 3'd4
	} op_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_AMP_ATTACK  = 3'd0,
		CFG_AMP_RELEASE = 3'd1,
		CFG_PITCH_ENV   = 3'd2,
		CFG_ENV_LENGTH  = 3'd3,
		CFG_AMP_LOOP    = 3'd4,
		CFG_PITCH_LOOP  = 3'd5
	} cfg_idx_t;

	// MIDI message the parser is collecting data bytes for.
	typedef enum logic [1:0] {
		MODE_UNKNOWN  = 2'd0,
		MODE_NOTE_ON  = 2'd1,
		MODE_NOTE_OFF = 2'd2
	} mode_t;

	// DAC targets.
	localparam logic TGT_AMP   = 1'b0;
	localparam logic TGT_PITCH = 1'b1;

	// MIDI status nibbles.
	localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
	localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;

	// Reset values.
	localparam logic [VAL_W-1:0]  LEVEL_RESET   = 16'd35000;
	localparam logic [SEL_W-1:0]  ATTACK_RESET  = 4'd11;
	localparam logic [SEL_W-1:0]  RELEASE_RESET = 4'd12;
	localparam logic [SEL_W-1:0]  PITCH_RESET   = 4'd11;
	localparam logic [STEP_W-1:0] LENGTH_RESET  = 8'd101;

	// Table access request from the sequencer to the table memories.
	typedef struct packed {
		logic              pt_we;
		logic              lt_we;
		logic              env_we;
		logic [NOTE_W-1:0] wr_idx;
		logic [SEL_W-1:0]  wr_sel;
		logic [VAL_W-1:0]  wr_data;
		logic [NOTE_W-1:0] pt_raddr;
		logic [NOTE_W-1:0] lt_raddr;
		logic [SEL_W-1:0]  rd_sel;
		logic [STEP_W-1:0] rd_step;
	} mem_req_t;

endpackage

// ===== rtl/midi_note_envelope_controller_top.sv =====
// Top level of the MIDI note envelope controller: MIDI parser, envelope sequencer,
// configuration registers. Depends on mnec_pkg, mnec_alu, mnec_mem and the defines header.
//
// Usage:
// An input word (operation, midi_byte, table_sel, table_index, table_value) is taken
// when start is high and busy is low. Operation 0 feeds one raw MIDI byte, 1 is an
// envelope tick, 2 to 4 write the pitch, level and envelope tables.
// Results come out as DAC writes (dac_target, dac_code, last), each valid for the one
// cycle in which result_strobe is high; the receiver cannot hold them off. last marks
// the final write caused by a word. A word causes zero, one or two writes.
// Configuration registers are written through cfg_valid/cfg_ready, cfg_index and
// cfg_data; the user must write them only while the block is idle, and cfg_ready is
// always high, so the block itself does not enforce this. Table loads, status bytes and
// most data bytes keep busy low, while a tick, a completed note-on and a note-off with
// a nonzero note number raise it. Each envelope passes a check state (ST_CHK) and,
// unless skipped, an add state (ST_ADD) using the table read and the single shared
// adder and comparator; a flush state (ST_FLUSH) then releases the last write.
// Reset clears the parser, goals, envelope positions and the configuration registers
// to their defaults; the table memories hold no reset value and must be loaded first.
module midi_note_envelope_controller_top #(
	parameter int ENV_DEPTH  = 128,
	parameter int ENV_TABLES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  operation,
	input  logic [7:0]                  midi_byte,
	input  logic [mnec_pkg::SEL_W-1:0]  table_sel,
	input  logic [mnec_pkg::NOTE_W-1:0] table_index,
	input  logic [mnec_pkg::VAL_W-1:0]  table_value,
	output logic                        result_strobe,
	output logic                        dac_target,
	output logic [mnec_pkg::CODE_W-1:0] dac_code,
	output logic                        last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [7:0]                  cfg_data
);

	`include "midi_note_envelope_controller_top_defines.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NOTE_LD,
		ST_OFF_CMP,
		ST_CHK,
		ST_ADD,
		ST_FLUSH
	} state_t;

	state_t                        state_q;
	mnec_pkg::op_t                 op_in;
	logic                          accept;

	// Configuration registers.
	logic [mnec_pkg::SEL_W-1:0]    amp_attack_q;
	logic [mnec_pkg::SEL_W-1:0]    amp_release_q;
	logic [mnec_pkg::SEL_W-1:0]    pitch_env_q;
	logic [mnec_pkg::STEP_W-1:0]   env_length_q;
	logic                          amp_loop_q;
	logic                          pitch_loop_q;

	// Parser and envelope state.
	mnec_pkg::mode_t               mode_q;
	logic                          have_note_q;
	logic                          have_level_q;
	logic [mnec_pkg::NOTE_W-1:0]   pending_q;
	logic [mnec_pkg::VAL_W-1:0]    pitch_goal_q;
	logic [mnec_pkg::VAL_W-1:0]    level_goal_q;
	logic [mnec_pkg::VAL_W-1:0]    pitch_sent_q;
	logic [mnec_pkg::VAL_W-1:0]    level_sent_q;
	logic [mnec_pkg::STEP_W-1:0]   amp_step_q;
	logic [mnec_pkg::STEP_W-1:0]   pitch_step_q;
	logic                          releasing_q;

	// Sequencer bookkeeping.
	logic                          unit_q;
	logic                          restart_q;
	logic                          more_q;
	logic                          env_ok_q;
	logic                          pend_valid_q;
	logic                          pend_target_q;
	logic [mnec_pkg::CODE_W-1:0]   pend_code_q;

	// Output registers.
	logic                          strobe_q;
	logic                          target_q;
	logic [mnec_pkg::CODE_W-1:0]   code_q;
	logic                          last_q;

	// Datapath signals.
	mnec_pkg::mem_req_t            mem_req;
	logic [mnec_pkg::VAL_W-1:0]    pitch_q;
	logic [mnec_pkg::VAL_W-1:0]    level_q;
	logic [mnec_pkg::VAL_W-1:0]    env_q;
	logic [mnec_pkg::VAL_W-1:0]    alu_a;
	logic [mnec_pkg::VAL_W-1:0]    alu_b;
	logic [mnec_pkg::VAL_W-1:0]    alu_c;
	logic [mnec_pkg::VAL_W-1:0]    alu_sum;
	logic                          alu_ne;
	logic [mnec_pkg::STEP_W-1:0]   eff_len;
	logic [mnec_pkg::STEP_W-1:0]   cur_step;
	logic [mnec_pkg::STEP_W-1:0]   step_eff;
	logic [mnec_pkg::STEP_W-1:0]   run_step;
	logic                          at_end;
	logic                          cur_loop;
	logic                          skip;
	logic [mnec_pkg::SEL_W-1:0]    cur_tbl;
	logic                          is_pitch;

	assign op_in         = mnec_pkg::op_t'(operation);
	assign accept        = start && !busy;
	assign busy          = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign result_strobe = strobe_q;
	assign dac_target    = target_q;
	assign dac_code      = code_q;
	assign last          = last_q;
	assign is_pitch      = (unit_q == mnec_pkg::TGT_PITCH);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_attack_q  <= mnec_pkg::ATTACK_RESET;
			amp_release_q <= mnec_pkg::RELEASE_RESET;
			pitch_env_q   <= mnec_pkg::PITCH_RESET;
			env_length_q  <= mnec_pkg::LENGTH_RESET;
			amp_loop_q    <= 1'b0;
			pitch_loop_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (mnec_pkg::cfg_idx_t'(cfg_index))
				mnec_pkg::CFG_AMP_ATTACK:  amp_attack_q  <= cfg_data[mnec_pkg::SEL_W-1:0];
				mnec_pkg::CFG_AMP_RELEASE: amp_release_q <= cfg_data[mnec_pkg::SEL_W-1:0];
				mnec_pkg::CFG_PITCH_ENV:   pitch_env_q   <= cfg_data[mnec_pkg::SEL_W-1:0];
				mnec_pkg::CFG_ENV_LENGTH:  env_length_q  <= cfg_data;
				mnec_pkg::CFG_AMP_LOOP:    amp_loop_q    <= cfg_data[0];
				mnec_pkg::CFG_PITCH_LOOP:  pitch_loop_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective envelope length: zero acts as one, and it is bounded by the table depth.
	always_comb begin
		eff_len = (env_length_q == '0) ? mnec_pkg::STEP_W'(1) : env_length_q;
		if (int'(eff_len) > ENV_DEPTH) begin
			eff_len = mnec_pkg::STEP_W'(ENV_DEPTH);
		end
	end

	// Step selection for the envelope under way.
	always_comb begin
		cur_step = is_pitch ? pitch_step_q : amp_step_q;
		cur_loop = is_pitch ? pitch_loop_q : amp_loop_q;
		step_eff = restart_q ? '0 : cur_step;
		at_end   = (step_eff >= eff_len);
		skip     = at_end && !cur_loop;
		run_step = at_end ? '0 : step_eff;
		if (is_pitch) begin
			cur_tbl = pitch_env_q;
		end else begin
			cur_tbl = releasing_q ? amp_release_q : amp_attack_q;
		end
	end

	// Table requests: loads are written at acceptance, reads are issued every cycle.
	always_comb begin
		mem_req.pt_we    = accept && (op_in == mnec_pkg::OP_LOAD_PITCH);
		mem_req.lt_we    = accept && (op_in == mnec_pkg::OP_LOAD_LEVEL);
		mem_req.env_we   = accept && (op_in == mnec_pkg::OP_LOAD_ENV)
			&& (int'(table_sel) < ENV_TABLES) && (int'(table_index) < ENV_DEPTH);
		mem_req.wr_idx   = table_index;
		mem_req.wr_sel   = table_sel;
		mem_req.wr_data  = table_value;
		mem_req.pt_raddr = (mode_q == mnec_pkg::MODE_NOTE_ON) ? pending_q
			: midi_byte[mnec_pkg::NOTE_W-1:0];
		mem_req.lt_raddr = midi_byte[mnec_pkg::NOTE_W-1:0];
		mem_req.rd_sel   = cur_tbl;
		mem_req.rd_step  = run_step;
	end

	mnec_mem #(
		.ENV_DEPTH  (ENV_DEPTH),
		.ENV_TABLES (ENV_TABLES)
	) u_mem (
		.clk     (clk),
		.req     (mem_req),
		.pitch_q (pitch_q),
		.level_q (level_q),
		.env_q   (env_q)
	);

	// Operand selection for the shared adder and comparator.
	always_comb begin
		alu_a = is_pitch ? pitch_goal_q : level_goal_q;
		alu_b = env_ok_q ? env_q : '0;
		alu_c = is_pitch ? pitch_sent_q : level_sent_q;
		if (state_q == ST_OFF_CMP) begin
			alu_a = pitch_q;
			alu_b = '0;
			alu_c = pitch_goal_q;
		end
	end

	mnec_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.c   (alu_c),
		.sum (alu_sum),
		.ne  (alu_ne)
	);

	// Sequencer: parser, envelope runs and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= mnec_pkg::MODE_UNKNOWN;
			have_note_q   <= 1'b0;
			have_level_q  <= 1'b0;
			pending_q     <= '0;
			pitch_goal_q  <= '0;
			level_goal_q  <= mnec_pkg::LEVEL_RESET;
			pitch_sent_q  <= '0;
			level_sent_q  <= mnec_pkg::LEVEL_RESET;
			amp_step_q    <= '0;
			pitch_step_q  <= '0;
			releasing_q   <= 1'b0;
			unit_q        <= mnec_pkg::TGT_AMP;
			restart_q     <= 1'b0;
			more_q        <= 1'b0;
			env_ok_q      <= 1'b0;
			pend_valid_q  <= 1'b0;
			pend_target_q <= mnec_pkg::TGT_AMP;
			pend_code_q   <= '0;
			strobe_q      <= 1'b0;
			target_q      <= mnec_pkg::TGT_AMP;
			code_q        <= '0;
			last_q        <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (op_in)
							mnec_pkg::OP_MIDI: begin
								if (midi_byte[7]) begin
									// A status byte starts a new message.
									have_note_q  <= 1'b0;
									have_level_q <= 1'b0;
									if (midi_byte[7:4] == mnec_pkg::STATUS_NOTE_OFF) begin
										mode_q <= mnec_pkg::MODE_NOTE_OFF;
									end else if (midi_byte[7:4] == mnec_pkg::STATUS_NOTE_ON) begin
										mode_q <= mnec_pkg::MODE_NOTE_ON;
									end
								end else begin
									case (mode_q)
										mnec_pkg::MODE_NOTE_ON: begin
											if (!have_note_q) begin
												pending_q   <= midi_byte[mnec_pkg::NOTE_W-1:0];
												have_note_q <= 1'b1;
											end else if (!have_level_q) begin
												have_level_q <= 1'b1;
												state_q      <= ST_NOTE_LD;
											end
										end
										mnec_pkg::MODE_NOTE_OFF: begin
											if (!have_note_q) begin
												pending_q   <= midi_byte[mnec_pkg::NOTE_W-1:0];
												have_note_q <= 1'b1;
												if (midi_byte != '0) begin
													state_q <= ST_OFF_CMP;
												end
											end else if (!have_level_q) begin
												have_level_q <= 1'b1;
											end
										end
										default: ;
									endcase
								end
							end
							mnec_pkg::OP_TICK: begin
								unit_q    <= mnec_pkg::TGT_AMP;
								restart_q <= 1'b0;
								more_q    <= 1'b1;
								state_q   <= ST_CHK;
							end
							default: ;
						endcase
					end
				end
				ST_NOTE_LD: begin
					// Note-on: goals from the tables, pitch envelope first.
					pitch_goal_q <= pitch_q;
					level_goal_q <= level_q;
					releasing_q  <= 1'b0;
					unit_q       <= mnec_pkg::TGT_PITCH;
					restart_q    <= 1'b1;
					more_q       <= 1'b1;
					state_q      <= ST_CHK;
				end
				ST_OFF_CMP: begin
					// Note-off releases only when its pitch matches the sounding one.
					if (!alu_ne) begin
						releasing_q <= 1'b1;
						unit_q      <= mnec_pkg::TGT_AMP;
						restart_q   <= 1'b1;
						more_q      <= 1'b0;
						state_q     <= ST_CHK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHK: begin
					if (skip) begin
						if (more_q) begin
							unit_q <= !unit_q;
							more_q <= 1'b0;
						end else begin
							state_q <= ST_FLUSH;
						end
					end else begin
						if (is_pitch) begin
							pitch_step_q <= run_step;
						end else begin
							amp_step_q <= run_step;
						end
						env_ok_q <= (int'(cur_tbl) < ENV_TABLES);
						state_q  <= ST_ADD;
					end
				end
				ST_ADD: begin
					// A changed value becomes the pending write; the older one goes out.
					if (alu_ne) begin
						if (is_pitch) begin
							pitch_sent_q <= alu_sum;
						end else begin
							level_sent_q <= alu_sum;
						end
						if (pend_valid_q) begin
							strobe_q <= 1'b1;
							target_q <= pend_target_q;
							code_q   <= pend_code_q;
						end
						pend_valid_q  <= 1'b1;
						pend_target_q <= unit_q;
						pend_code_q   <= alu_sum[mnec_pkg::VAL_W-1:mnec_pkg::VAL_W-mnec_pkg::CODE_W];
					end
					if (is_pitch) begin
						pitch_step_q <= pitch_step_q + 1'b1;
					end else begin
						amp_step_q <= amp_step_q + 1'b1;
					end
					if (more_q) begin
						unit_q  <= !unit_q;
						more_q  <= 1'b0;
						state_q <= ST_CHK;
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (pend_valid_q) begin
						strobe_q     <= 1'b1;
						target_q     <= pend_target_q;
						code_q       <= pend_code_q;
						last_q       <= 1'b1;
						pend_valid_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A write is only released while a word is being worked on.
	`MNEC_ASSERT(a_strobe_after_busy, result_strobe |-> $past(busy))
	// The last marker never stands without a write.
	`MNEC_ASSERT(a_last_has_strobe, last |-> result_strobe)
	// A held-back write exists only while the sequencer runs.
	`MNEC_ASSERT(a_pending_busy, pend_valid_q |-> busy)
	// A tick always occupies the sequencer.
	`MNEC_ASSERT_NEXT(a_tick_busy, start && !busy && (operation == 3'd1), busy)

endmodule

// ===== rtl/mnec_alu.sv =====
// Shared add and compare unit of the MIDI note envelope controller.
// Depends on mnec_pkg for widths.
module mnec_alu (
	input  logic [mnec_pkg::VAL_W-1:0] a,
	input  logic [mnec_pkg::VAL_W-1:0] b,
	input  logic [mnec_pkg::VAL_W-1:0] c,
	output logic [mnec_pkg::VAL_W-1:0] sum,
	output logic                       ne
);

	// The sum wraps at 16 bits and is compared with the reference value.
	assign sum = a + b;
	assign ne  = (sum != c);

endmodule

// ===== rtl/mnec_mem.sv =====
// Pitch, level and envelope table memories with registered reads.
// Depends on mnec_pkg for the request struct.
module mnec_mem #(
	parameter int ENV_DEPTH  = 128,
	parameter int ENV_TABLES = 16
) (
	input  logic                       clk,
	input  mnec_pkg::mem_req_t         req,
	output logic [mnec_pkg::VAL_W-1:0] pitch_q,
	output logic [mnec_pkg::VAL_W-1:0] level_q,
	output logic [mnec_pkg::VAL_W-1:0] env_q
);

	localparam int NOTES = 1 << mnec_pkg::NOTE_W;
	localparam int AW    = $clog2(ENV_TABLES * ENV_DEPTH);

	logic [mnec_pkg::VAL_W-1:0] pitch_mem [NOTES];
	logic [mnec_pkg::VAL_W-1:0] level_mem [NOTES];
	logic [mnec_pkg::VAL_W-1:0] env_mem   [ENV_TABLES * ENV_DEPTH];
	logic [AW-1:0]              env_waddr;
	logic [AW-1:0]              env_raddr;

	// Envelope tables sit one after another in a single memory.
	assign env_waddr = AW'(AW'(req.wr_sel) * AW'(ENV_DEPTH) + AW'(req.wr_idx));
	assign env_raddr = AW'(AW'(req.rd_sel) * AW'(ENV_DEPTH) + AW'(req.rd_step));

	// Pitch table.
	always_ff @(posedge clk) begin
		if (req.pt_we) begin
			pitch_mem[req.wr_idx] <= req.wr_data;
		end
		pitch_q <= pitch_mem[req.pt_raddr];
	end

	// Level table.
	always_ff @(posedge clk) begin
		if (req.lt_we) begin
			level_mem[req.wr_idx] <= req.wr_data;
		end
		level_q <= level_mem[req.lt_raddr];
	end

	// Envelope store.
	always_ff @(posedge clk) begin
		if (req.env_we) begin
			env_mem[env_waddr] <= req.wr_data;
		end
		env_q <= env_mem[env_raddr];
	end

endmodule
